/* src/pressure_sensor_compensation_assert.svh */
// assertion macros for the pressure compensation pipeline
`ifndef PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define PSC_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define PSC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* src/psc_pkg.sv */
// shared widths, register codes and helpers for the pressure compensation block
`timescale 1ns / 1ps

package psc_pkg;

	localparam int RawW      = 24;
	localparam int CalW      = 16;
	localparam int OutW      = 32;
	localparam int CfgIdxW   = 3;
	localparam int PipeDepth = 10;

	typedef logic [CfgIdxW-1:0] reg_idx_t;

	// calibration register codes
	localparam reg_idx_t RegC1 = 3'd0;
	localparam reg_idx_t RegC2 = 3'd1;
	localparam reg_idx_t RegC3 = 3'd2;
	localparam reg_idx_t RegC4 = 3'd3;
	localparam reg_idx_t RegC5 = 3'd4;
	localparam reg_idx_t RegC6 = 3'd5;

	// temperature offsets, in hundredths of a degree
	localparam logic signed [19:0] TRefOffset  = 20'sd2000;
	localparam logic signed [19:0] TColdOffset = 20'sd3500;
	// first-order delta below which the cold correction applies
	localparam logic signed [18:0] DTempCold   = -19'sd3500;

	// signed divide by 2^k, rounding toward zero
	function automatic logic signed [31:0] trunc_div_pow2(input logic signed [31:0] x,
		input logic [2:0] k);
		logic signed [32:0] xe;
		logic        [32:0] bias;
		logic signed [32:0] sum;
		xe   = $signed({x[31], x});
		bias = x[31] ? ((33'd1 << k) - 33'd1) : 33'd0;
		sum  = xe + $signed(bias);
		return 32'(sum >>> k);
	endfunction

endpackage

/* src/pressure_sensor_compensation.sv */
// pressure compensation top level: ten-stage second-order compensation pipeline
`timescale 1ns / 1ps

// usage
//  - calibration words C1..C6 are written through cfg_we / cfg_index / cfg_data,
//    one word per clock, indexes 0 to 5; other indexes are ignored; write them
//    only while no request is in flight
//  - input channel in_valid / in_ready carries one request: raw_pressure (D1)
//    and raw_temperature (D2), both 24-bit unsigned
//  - output channel out_valid / out_ready returns one result per request:
//    temperature_centideg (0.01 C) and pressure_decimbar (0.1 mbar), signed
//  - each result passes through the ten register stages; throughput is one
//    request per cycle while the receiver does not stall the output
//  - the stages are: offset subtract, first products, temperature and squares,
//    second-order terms, offset and sensitivity, split pressure product,
//    product sum, first scale, offset subtract, final scale into the output
//  - a stalled receiver holds the last stage; each stage holds only while it is
//    full and the stage after it cannot move, so empty slots close up and
//    in_ready drops only when all ten stages are full and out_ready is low
//  - reset clears the calibration words to zero and empties the pipeline

module pressure_sensor_compensation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [psc_pkg::CalW-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [psc_pkg::RawW-1:0]    raw_pressure,
	input  logic [psc_pkg::RawW-1:0]    raw_temperature,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [psc_pkg::OutW-1:0] temperature_centideg,
	output logic signed [psc_pkg::OutW-1:0] pressure_decimbar
);
	import psc_pkg::*;

	// calibration words
	logic [CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	// per-stage valid bits and advance enables
	logic [PipeDepth:1] vld_q;
	logic [PipeDepth:1] en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegC1: c1_q <= cfg_data;
				RegC2: c2_q <= cfg_data;
				RegC3: c3_q <= cfg_data;
				RegC4: c4_q <= cfg_data;
				RegC5: c5_q <= cfg_data;
				RegC6: c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		en[PipeDepth] = ~vld_q[PipeDepth] | out_ready;
		for (int k = PipeDepth - 1; k >= 1; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[PipeDepth];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= PipeDepth; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: dT = D2 - C5 * 256
	logic signed [24:0] dt_c, dt_s1;
	logic [RawW-1:0]    d1_s1;

	assign dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_q, 8'h00});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dt_s1 <= dt_c;
			d1_s1 <= raw_pressure;
		end
	end

	// stage 2: the four products on dT
	logic signed [41:0] dtc6_c, c4dt_c, c3dt_c;
	logic signed [49:0] dtsq_c;
	logic signed [41:0] dtc6_s2, c4dt_s2, c3dt_s2;
	logic [47:0]        dtsq_s2;
	logic [RawW-1:0]    d1_s2;

	assign dtc6_c = dt_s1 * $signed({1'b0, c6_q});
	assign c4dt_c = dt_s1 * $signed({1'b0, c4_q});
	assign c3dt_c = dt_s1 * $signed({1'b0, c3_q});
	assign dtsq_c = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dtc6_s2 <= dtc6_c;
			c4dt_s2 <= c4dt_c;
			c3dt_s2 <= c3dt_c;
			dtsq_s2 <= dtsq_c[47:0];
			d1_s2   <= d1_s1;
		end
	end

	// stage 3: first-order temperature, the two squares, T2 and the base terms
	logic signed [18:0] dtemp_c;
	logic signed [19:0] t_c, tc_c;
	logic signed [37:0] qsq_c;
	logic signed [39:0] rsq_c;
	logic [16:0]        t2_lo_c, t2_c;
	logic [50:0]        dtsq7_c;
	logic signed [36:0] off_base_c, sens_base_c;
	logic               below_c, cold_c;

	logic signed [31:0] q_s3, r_s3;
	logic signed [19:0] t_s3;
	logic [16:0]        t2_s3;
	logic signed [36:0] off_base_s3, sens_base_s3;
	logic               below_s3, cold_s3;
	logic [RawW-1:0]    d1_s3;

	// floor shift by 23 is the top slice of the product
	assign dtemp_c = dtc6_s2[41:23];
	assign t_c     = $signed({dtemp_c[18], dtemp_c}) + TRefOffset;
	assign tc_c    = $signed({dtemp_c[18], dtemp_c}) + TColdOffset;
	assign qsq_c   = dtemp_c * dtemp_c;
	assign rsq_c   = tc_c * tc_c;
	// below 20 C when the first-order delta is negative
	assign below_c = dtemp_c[18];
	assign cold_c  = dtemp_c < DTempCold;

	// T2: 3 * (dT^2 >> 33) when below 20 C, (7 * dT^2) >> 37 otherwise
	assign t2_lo_c = {2'b00, dtsq_s2[47:33]} + {1'b0, dtsq_s2[47:33], 1'b0};
	assign dtsq7_c = {dtsq_s2, 3'b000} - {3'b000, dtsq_s2};
	assign t2_c    = below_c ? t2_lo_c : {3'b000, dtsq7_c[50:37]};

	assign off_base_c  = $signed({5'b0, c2_q, 16'h0000})
		+ $signed({{2{c4dt_s2[41]}}, c4dt_s2[41:7]});
	assign sens_base_c = $signed({6'b0, c1_q, 15'h0000})
		+ $signed({{3{c3dt_s2[41]}}, c3dt_s2[41:8]});

	always_ff @(posedge clk) begin
		if (en[3]) begin
			q_s3         <= qsq_c[31:0];
			r_s3         <= rsq_c[31:0];
			t_s3         <= t_c;
			t2_s3        <= t2_c;
			off_base_s3  <= off_base_c;
			sens_base_s3 <= sens_base_c;
			below_s3     <= below_c;
			cold_s3      <= cold_c;
			d1_s3        <= d1_s2;
		end
	end

	// stage 4: OFF2, SENS2 and the final temperature
	logic signed [31:0] q3_c, q5_c, r7_c, r4_c, h3_c, h5_c, q16_c;
	logic signed [33:0] off2_c, sens2_c;
	logic signed [20:0] tt_c;

	logic signed [33:0] off2_s4, sens2_s4;
	logic signed [36:0] off_base_s4, sens_base_s4;
	logic signed [31:0] temp_s4;
	logic [RawW-1:0]    d1_s4;
	// below flag as seen at stage 4, for the checks at the end
	logic               below_s4;

	// products wrap to 32 bits before their divisions
	assign q3_c  = q_s3 + $signed({q_s3[30:0], 1'b0});
	assign q5_c  = q_s3 + $signed({q_s3[29:0], 2'b00});
	assign r7_c  = $signed({r_s3[28:0], 3'b000}) - r_s3;
	assign r4_c  = $signed({r_s3[29:0], 2'b00});
	assign h3_c  = trunc_div_pow2(q3_c, 3'd1);
	assign h5_c  = trunc_div_pow2(q5_c, 3'd3);
	assign q16_c = trunc_div_pow2(q_s3, 3'd4);

	assign off2_c = below_s3
		? ($signed({{2{h3_c[31]}}, h3_c})
			+ (cold_s3 ? $signed({{2{r7_c[31]}}, r7_c}) : 34'sd0))
		: $signed({{2{q16_c[31]}}, q16_c});
	assign sens2_c = below_s3
		? ($signed({{2{h5_c[31]}}, h5_c})
			+ (cold_s3 ? $signed({{2{r4_c[31]}}, r4_c}) : 34'sd0))
		: 34'sd0;

	assign tt_c = $signed({t_s3[19], t_s3}) - $signed({4'b0000, t2_s3});

	always_ff @(posedge clk) begin
		if (en[4]) begin
			off2_s4      <= off2_c;
			sens2_s4     <= sens2_c;
			off_base_s4  <= off_base_s3;
			sens_base_s4 <= sens_base_s3;
			temp_s4      <= $signed({{11{tt_c[20]}}, tt_c});
			d1_s4        <= d1_s3;
			below_s4     <= below_s3;
		end
	end

	// stage 5: OFF and SENS
	logic signed [37:0] off_c, sens_c;
	logic signed [37:0] off_s5, sens_s5;
	logic signed [31:0] temp_s5;
	logic [RawW-1:0]    d1_s5;

	assign off_c  = $signed({off_base_s4[36], off_base_s4})
		- $signed({{4{off2_s4[33]}}, off2_s4});
	assign sens_c = $signed({sens_base_s4[36], sens_base_s4})
		- $signed({{4{sens2_s4[33]}}, sens2_s4});

	always_ff @(posedge clk) begin
		if (en[5]) begin
			off_s5  <= off_c;
			sens_s5 <= sens_c;
			temp_s5 <= temp_s4;
			d1_s5   <= d1_s4;
		end
	end

	// stage 6: SENS * D1 as two partial products on the halves of SENS
	logic [42:0]        pplo_c;
	logic signed [43:0] pphi_c;
	logic [42:0]        pplo_s6;
	logic signed [43:0] pphi_s6;
	logic signed [37:0] off_s6;
	logic signed [31:0] temp_s6;

	assign pplo_c = sens_s5[18:0] * d1_s5;
	assign pphi_c = $signed(sens_s5[37:19]) * $signed({1'b0, d1_s5});

	always_ff @(posedge clk) begin
		if (en[6]) begin
			pplo_s6 <= pplo_c;
			pphi_s6 <= pphi_c;
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;
		end
	end

	// stage 7: recombine the partial products
	logic signed [62:0] prod_c, prod_s7;
	logic signed [37:0] off_s7;
	logic signed [31:0] temp_s7;

	assign prod_c = $signed({pphi_s6, 19'h00000}) + $signed({20'h00000, pplo_s6});

	always_ff @(posedge clk) begin
		if (en[7]) begin
			prod_s7 <= prod_c;
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
		end
	end

	// stage 8: divide by 2^21 toward zero
	logic signed [62:0] psum_c;
	logic signed [41:0] a_s8;
	logic signed [37:0] off_s8;
	logic signed [31:0] temp_s8;

	assign psum_c = prod_s7 + (prod_s7[62] ? 63'sd2097151 : 63'sd0);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			a_s8    <= psum_c[62:21];
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// stage 9: subtract OFF
	logic signed [42:0] b_c, b_s9;
	logic signed [31:0] temp_s9;

	assign b_c = $signed({a_s8[41], a_s8}) - $signed({{5{off_s8[37]}}, off_s8});

	always_ff @(posedge clk) begin
		if (en[9]) begin
			b_s9    <= b_c;
			temp_s9 <= temp_s8;
		end
	end

	// stage 10: divide by 2^15 toward zero into the output register
	logic signed [42:0] bsum_c;
	logic signed [31:0] pres_s10, temp_s10;

	assign bsum_c = b_s9 + (b_s9[42] ? 43'sd32767 : 43'sd0);

	always_ff @(posedge clk) begin
		if (en[10]) begin
			pres_s10 <= $signed({{4{bsum_c[42]}}, bsum_c[42:15]});
			temp_s10 <= temp_s9;
		end
	end

	assign temperature_centideg = temp_s10;
	assign pressure_decimbar    = pres_s10;

	`include "pressure_sensor_compensation_assert.svh"

	// an accepted request always lands in the first stage
	`PSC_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_q[1], "accepted request lost")
	// the input side only blocks when the whole pipe is full and the output stalls
	`PSC_ASSERT_NOW(a_block_full, !in_ready, out_valid && !out_ready, "in_ready low with room")
	// the cold band lies inside the below-20 band
	`PSC_ASSERT_NOW(a_cold_below, vld_q[3] && cold_s3, below_s3, "cold flag without below")
	// no sensitivity correction at or above 20 C
	`PSC_ASSERT_NOW(a_warm_sens2, vld_q[4] && !below_s4, sens2_s4 == 34'sd0, "warm SENS2 not zero")

endmodule
